// File: rtl/c1pq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c1pq_pkg
// Shared widths, status codes and saturating Q24.40 helpers.
// ----------------------------------------------------------------------------
package c1pq_pkg;

  localparam int unsigned QW       = 64;
  localparam int unsigned QFRAC    = 40;
  localparam int unsigned QMUL_LAT = 4;
  localparam int unsigned NREG     = 7;
  localparam int unsigned IDXW     = 3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ORDER    = 2'd1;
  localparam logic [1:0] STAT_SINGULAR = 2'd2;
  localparam logic [1:0] STAT_SAT      = 2'd3;

  localparam logic [IDXW-1:0] REG_KNOT_LOW  = 3'd0;
  localparam logic [IDXW-1:0] REG_KNOT_HIGH = 3'd1;
  localparam logic [IDXW-1:0] REG_LEFT_K    = 3'd2;
  localparam logic [IDXW-1:0] REG_LEFT_L    = 3'd3;
  localparam logic [IDXW-1:0] REG_MID_K     = 3'd4;
  localparam logic [IDXW-1:0] REG_RIGHT_K   = 3'd5;
  localparam logic [IDXW-1:0] REG_RIGHT_Q   = 3'd6;

  localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic                 ovf;
    logic signed [QW-1:0] val;
  } sres_t;

  function automatic sres_t sat_add(input logic signed [QW-1:0] a,
                                    input logic signed [QW-1:0] b);
    logic signed [QW-1:0] r;
    sres_t                o;
    r     = a + b;
    o.ovf = (a[QW-1] == b[QW-1]) && (r[QW-1] != a[QW-1]);
    o.val = o.ovf ? (a[QW-1] ? QMIN : QMAX) : r;
    return o;
  endfunction

  function automatic sres_t sat_sub(input logic signed [QW-1:0] a,
                                    input logic signed [QW-1:0] b);
    logic signed [QW-1:0] r;
    sres_t                o;
    r     = a - b;
    o.ovf = (a[QW-1] != b[QW-1]) && (r[QW-1] != a[QW-1]);
    o.val = o.ovf ? (a[QW-1] ? QMIN : QMAX) : r;
    return o;
  endfunction

  function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] a);
    return a[QW-1] ? (~a + 1'b1) : a;
  endfunction

  // Clamp an unsigned magnitude (upper part must be zero) to signed range
  function automatic sres_t clamp_mag(input logic        hi_nz,
                                      input logic [QW-1:0] lo,
                                      input logic        neg);
    logic [QW-1:0] lim;
    sres_t         o;
    lim   = neg ? QMIN : QMAX;
    o.ovf = hi_nz || (lo > lim);
    o.val = o.ovf ? (neg ? QMIN : QMAX) : (neg ? (~lo + 1'b1) : lo);
    return o;
  endfunction

endpackage
`default_nettype wire

// File: rtl/c1_piecewise_quadratic_eval_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c1_piecewise_quadratic_eval_core
// Slope-continuous three-segment quadratic evaluator with two knots.
// ----------------------------------------------------------------------------
// Takes one sample point per cycle once the derived coefficients are ready
// and the result side is not stalling; each result passes through eleven
// register stages: select, two four-stage multipliers, add and output. After
// any configuration write the four derived coefficients are recomputed by one
// shared bit-serial divider: four divisions, each a load, one step per bit of
// the 128-bit quotient and a rounding step, then three finishing steps; all
// the while in_tready stays low.
module c1_piecewise_quadratic_eval_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire  [63:0]        in_tdata,    // [63:0] sample_point
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [63:0]        out_tdata,   // [63:0] curve_value
  output logic [1:0]         out_tuser,   // [1:0] eval_status
  input  wire                cfg_we,
  input  wire  [c1pq_pkg::IDXW-1:0] cfg_index,
  input  wire  [63:0]        cfg_wdata
);

  localparam int unsigned L = c1pq_pkg::QMUL_LAT;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_DRND = 3'd3;
  localparam logic [2:0] ST_FIN1 = 3'd4;
  localparam logic [2:0] ST_FIN2 = 3'd5;
  localparam logic [2:0] ST_FIN3 = 3'd6;

  // configuration
  logic signed [63:0] kl_r, kh_r, lk_r, ll_r, mk_r, rk_r, rq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kl_r <= '0; kh_r <= '0; lk_r <= '0; ll_r <= '0;
      mk_r <= '0; rk_r <= '0; rq_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c1pq_pkg::REG_KNOT_LOW:  kl_r <= cfg_wdata;
        c1pq_pkg::REG_KNOT_HIGH: kh_r <= cfg_wdata;
        c1pq_pkg::REG_LEFT_K:    lk_r <= cfg_wdata;
        c1pq_pkg::REG_LEFT_L:    ll_r <= cfg_wdata;
        c1pq_pkg::REG_MID_K:     mk_r <= cfg_wdata;
        c1pq_pkg::REG_RIGHT_K:   rk_r <= cfg_wdata;
        c1pq_pkg::REG_RIGHT_Q:   rq_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // coefficient sequencer with shared restoring divider
  logic [2:0]   st_r, st_nxt;
  logic [1:0]   dstep_r;
  logic [6:0]   cnt_r;
  logic [127:0] dvd_r, quo_r;
  logic [63:0]  rem_r, dsr_r;
  logic         dneg_r;
  logic signed [63:0] r0_r, r1_r, d0_r, d1_r, e_r, rr0_r, rr1_r;
  logic         bsat_r, d0sat_r, d1sat_r, esat_r, rr0sat_r, rr1sat_r, b1sat_r;
  logic signed [63:0] a2_r, b1_r, b2_r, c1_r;
  logic         sat0_r, sat1_r, sat2_r;

  c1pq_pkg::sres_t s0, s1, dres, fe, frr0, frr1, fa2, fb1, fc1;
  logic signed [63:0] num, den;
  logic [63:0]  remsh, remd;
  logic         take;
  logic [127:0] qr;

  assign s0 = c1pq_pkg::sat_sub(lk_r, mk_r);
  assign s1 = c1pq_pkg::sat_sub(mk_r, rk_r);

  always_comb begin
    case (dstep_r)
      2'd0:    begin num = s0.val; den = kl_r; end
      2'd1:    begin num = s1.val; den = kh_r; end
      2'd2:    begin num = r1_r;   den = kh_r; end
      default: begin num = r0_r;   den = kl_r; end
    endcase
  end

  assign remsh = {rem_r[62:0], dvd_r[127]};
  assign take  = rem_r[63] | (remsh >= dsr_r);
  assign remd  = take ? (remsh - dsr_r) : remsh;
  assign qr    = quo_r + {127'd0, (rem_r >= (dsr_r - rem_r))};
  assign dres  = c1pq_pkg::clamp_mag(|qr[127:64], qr[63:0], dneg_r);

  assign fe   = c1pq_pkg::sat_add(rq_r, d1_r);
  assign frr0 = c1pq_pkg::sat_add(r0_r, r0_r);
  assign frr1 = c1pq_pkg::sat_add(r1_r, r1_r);
  assign fa2  = c1pq_pkg::sat_add(e_r, d0_r);
  assign fb1  = c1pq_pkg::sat_add(ll_r, rr0_r);
  assign fc1  = c1pq_pkg::sat_add(b1_r, rr1_r);

  always_comb begin
    st_nxt = st_r;
    if (cfg_we) begin
      st_nxt = ST_LOAD;
    end else begin
      unique case (st_r)
        ST_IDLE: st_nxt = ST_IDLE;
        ST_LOAD: st_nxt = ST_DIV;
        ST_DIV:  st_nxt = (cnt_r == 7'd127) ? ST_DRND : ST_DIV;
        ST_DRND: st_nxt = (dstep_r == 2'd3) ? ST_FIN1 : ST_LOAD;
        ST_FIN1: st_nxt = ST_FIN2;
        ST_FIN2: st_nxt = ST_FIN3;
        ST_FIN3: st_nxt = ST_IDLE;
        default: st_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      dstep_r <= '0;
      cnt_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        dstep_r <= '0;
      end else if (st_r == ST_DRND) begin
        dstep_r <= dstep_r + 2'd1;
      end
      if (st_r == ST_DIV) begin
        cnt_r <= cnt_r + 7'd1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_LOAD: begin
        dvd_r  <= {24'd0, c1pq_pkg::mag(num), 40'd0};
        dsr_r  <= c1pq_pkg::mag(den);
        dneg_r <= num[63] ^ den[63];
        quo_r  <= '0;
        rem_r  <= '0;
        if (dstep_r == 2'd0) begin
          bsat_r <= s0.ovf;
        end else if (dstep_r == 2'd1) begin
          bsat_r <= bsat_r | s1.ovf;
        end
      end
      ST_DIV: begin
        dvd_r <= {dvd_r[126:0], 1'b0};
        rem_r <= remd;
        quo_r <= {quo_r[126:0], take};
      end
      ST_DRND: begin
        case (dstep_r)
          2'd0:    begin r0_r <= dres.val; bsat_r <= bsat_r | dres.ovf; end
          2'd1:    begin r1_r <= dres.val; bsat_r <= bsat_r | dres.ovf; end
          2'd2:    begin d1_r <= dres.val; d1sat_r <= dres.ovf; end
          default: begin d0_r <= dres.val; d0sat_r <= dres.ovf; end
        endcase
      end
      ST_FIN1: begin
        e_r      <= fe.val;
        esat_r   <= fe.ovf | d1sat_r;
        rr0_r    <= frr0.val;
        rr0sat_r <= frr0.ovf;
        rr1_r    <= frr1.val;
        rr1sat_r <= frr1.ovf;
      end
      ST_FIN2: begin
        a2_r    <= fa2.val;
        sat0_r  <= bsat_r | esat_r | d0sat_r | fa2.ovf;
        b2_r    <= e_r;
        b1_r    <= fb1.val;
        b1sat_r <= fb1.ovf;
        sat1_r  <= bsat_r | esat_r | rr0sat_r | fb1.ovf;
      end
      ST_FIN3: begin
        c1_r   <= fc1.val;
        sat2_r <= bsat_r | rr0sat_r | b1sat_r | rr1sat_r | fc1.ovf;
      end
      default: ;
    endcase
  end

  // evaluation pipeline, held as a whole while the output item waits
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en && (st_r == ST_IDLE);

  logic signed [63:0] x_in;
  assign x_in = in_tdata;

  logic               va_r;
  logic signed [63:0] xa_r, ka_r, la_r, qa_r;
  logic               sata_r;
  logic [1:0]         stata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r <= x_in;
      if (kl_r > kh_r) begin
        stata_r <= c1pq_pkg::STAT_ORDER;
      end else if (kl_r == 64'sd0 || kh_r == 64'sd0) begin
        stata_r <= c1pq_pkg::STAT_SINGULAR;
      end else begin
        stata_r <= c1pq_pkg::STAT_OK;
      end
      if (x_in < kl_r) begin
        ka_r <= lk_r; la_r <= ll_r; qa_r <= a2_r; sata_r <= sat0_r;
      end else if (x_in < kh_r) begin
        ka_r <= mk_r; la_r <= b1_r; qa_r <= b2_r; sata_r <= sat1_r;
      end else begin
        ka_r <= rk_r; la_r <= c1_r; qa_r <= rq_r; sata_r <= sat2_r;
      end
    end
  end

  c1pq_pkg::sres_t p1, p2, tsum, vsum;

  c1pq_qmul u_mul_q (.clk(clk), .en(en), .a(xa_r), .b(qa_r), .res(p1));

  logic               v1_r   [L];
  logic signed [63:0] x1_r   [L];
  logic signed [63:0] k1_r   [L];
  logic signed [63:0] l1_r   [L];
  logic               sat1d_r[L];
  logic [1:0]         stat1_r[L];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) v1_r[i] <= 1'b0;
    end else if (en) begin
      v1_r[0] <= va_r;
      for (int i = 1; i < L; i++) v1_r[i] <= v1_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r[0] <= xa_r; k1_r[0] <= ka_r; l1_r[0] <= la_r;
      sat1d_r[0] <= sata_r; stat1_r[0] <= stata_r;
      for (int i = 1; i < L; i++) begin
        x1_r[i] <= x1_r[i-1]; k1_r[i] <= k1_r[i-1]; l1_r[i] <= l1_r[i-1];
        sat1d_r[i] <= sat1d_r[i-1]; stat1_r[i] <= stat1_r[i-1];
      end
    end
  end

  assign tsum = c1pq_pkg::sat_add(l1_r[L-1], p1.val);

  logic               vb_r;
  logic signed [63:0] xb_r, kb_r, tb_r;
  logic               satb_r;
  logic [1:0]         statb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= v1_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xb_r    <= x1_r[L-1];
      kb_r    <= k1_r[L-1];
      tb_r    <= tsum.val;
      satb_r  <= sat1d_r[L-1] | p1.ovf | tsum.ovf;
      statb_r <= stat1_r[L-1];
    end
  end

  c1pq_qmul u_mul_t (.clk(clk), .en(en), .a(xb_r), .b(tb_r), .res(p2));

  logic               v2_r   [L];
  logic signed [63:0] k2_r   [L];
  logic               sat2d_r[L];
  logic [1:0]         stat2_r[L];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) v2_r[i] <= 1'b0;
    end else if (en) begin
      v2_r[0] <= vb_r;
      for (int i = 1; i < L; i++) v2_r[i] <= v2_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2_r[0] <= kb_r; sat2d_r[0] <= satb_r; stat2_r[0] <= statb_r;
      for (int i = 1; i < L; i++) begin
        k2_r[i] <= k2_r[i-1]; sat2d_r[i] <= sat2d_r[i-1];
        stat2_r[i] <= stat2_r[i-1];
      end
    end
  end

  assign vsum = c1pq_pkg::sat_add(k2_r[L-1], p2.val);

  logic        ov_r;
  logic [63:0] oval_r;
  logic [1:0]  ostat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v2_r[L-1];
    end
  end

  // bad knots override any arithmetic result
  always_ff @(posedge clk) begin
    if (en) begin
      if (stat2_r[L-1] != c1pq_pkg::STAT_OK) begin
        oval_r  <= '0;
        ostat_r <= stat2_r[L-1];
      end else begin
        oval_r  <= vsum.val;
        ostat_r <= (sat2d_r[L-1] | p2.ovf | vsum.ovf) ? c1pq_pkg::STAT_SAT
                                                       : c1pq_pkg::STAT_OK;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = oval_r;
  assign out_tuser  = ostat_r;

  a_bad_knots_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == c1pq_pkg::STAT_ORDER ||
                   out_tuser == c1pq_pkg::STAT_SINGULAR) |-> out_tdata == 64'd0)
    else $error("error status with nonzero value");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input taken while coefficients are recomputed");

  a_div_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DRND) && (dstep_r == 2'd3) && !cfg_we |=> st_r == ST_FIN1)
    else $error("sequencer skipped finishing steps");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> st_r == ST_IDLE)
    else $error("ready while sequencer busy");

endmodule
`default_nettype wire

// File: rtl/c1pq_qmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c1pq_qmul
// Four-stage Q24.40 multiplier: magnitudes, 32x32 partial products, sum,
// round to nearest (ties away from zero) and saturate.
// ----------------------------------------------------------------------------
module c1pq_qmul (
  input  wire                               clk,
  input  wire                               en,
  input  wire logic signed [c1pq_pkg::QW-1:0] a,
  input  wire logic signed [c1pq_pkg::QW-1:0] b,
  output c1pq_pkg::sres_t                   res
);

  logic [63:0]  ma_r, mb_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] prod_r;
  logic [127:0] rnd;
  c1pq_pkg::sres_t res_r;

  assign rnd = prod_r + (128'd1 << (c1pq_pkg::QFRAC - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= c1pq_pkg::mag(a);
      mb_r   <= c1pq_pkg::mag(b);
      neg1_r <= a[63] ^ b[63];
      p00_r  <= ma_r[31:0]  * mb_r[31:0];
      p01_r  <= ma_r[31:0]  * mb_r[63:32];
      p10_r  <= ma_r[63:32] * mb_r[31:0];
      p11_r  <= ma_r[63:32] * mb_r[63:32];
      neg2_r <= neg1_r;
      prod_r <= {p11_r, 64'd0} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
                + {64'd0, p00_r};
      neg3_r <= neg2_r;
      res_r  <= c1pq_pkg::clamp_mag(|rnd[127:104], rnd[103:40], neg3_r);
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// File: verif/c1_piecewise_quadratic_eval_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c1_piecewise_quadratic_eval_checker
// Watches the sample, result and configuration ports of the evaluator core,
// predicts every curve value and status in Q24.40 and compares them in order.
// ----------------------------------------------------------------------------
module c1_piecewise_quadratic_eval_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [63:0] in_tdata,
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [63:0] out_tdata,
  input  wire [1:0]  out_tuser,
  input  wire        cfg_we,
  input  wire [c1pq_pkg::IDXW-1:0] cfg_index,
  input  wire [63:0] cfg_wdata,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic               ovf;
    logic signed [63:0] v;
  } qnum_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } curve_pt_t;

  logic signed [63:0] kl, kh, lk, ll, mk, rk, rq;
  curve_pt_t          curve_q[$];

  function automatic qnum_t q_add(logic signed [63:0] a, logic signed [63:0] b);
    qnum_t o;
    o.v   = a + b;
    o.ovf = (a[63] == b[63]) && (o.v[63] != a[63]);
    if (o.ovf) o.v = a[63] ? c1pq_pkg::QMIN : c1pq_pkg::QMAX;
    return o;
  endfunction

  function automatic qnum_t q_sub(logic signed [63:0] a, logic signed [63:0] b);
    qnum_t o;
    o.v   = a - b;
    o.ovf = (a[63] != b[63]) && (o.v[63] != a[63]);
    if (o.ovf) o.v = a[63] ? c1pq_pkg::QMIN : c1pq_pkg::QMAX;
    return o;
  endfunction

  function automatic logic [63:0] abs_q(logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic qnum_t fit_q(logic [127:0] m, logic neg);
    logic [63:0] lim;
    qnum_t       o;
    lim   = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    o.ovf = (m[127:64] != 0) || (m[63:0] > lim);
    if (o.ovf) o.v = neg ? c1pq_pkg::QMIN : c1pq_pkg::QMAX;
    else       o.v = neg ? (64'd0 - m[63:0]) : m[63:0];
    return o;
  endfunction

  // round to nearest, ties away from zero, on the magnitude
  function automatic qnum_t q_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] p;
    p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
    p = (p + (128'd1 << 39)) >> 40;
    return fit_q(p, a[63] != b[63]);
  endfunction

  function automatic qnum_t q_div(logic signed [63:0] n, logic signed [63:0] d);
    logic [127:0] num, den, quo, rem;
    num = {64'd0, abs_q(n)} << 40;
    den = {64'd0, abs_q(d)};
    quo = num / den;
    rem = num % den;
    if (rem >= den - rem) quo = quo + 1;
    return fit_q(quo, n[63] != d[63]);
  endfunction

  function automatic curve_pt_t eval_curve(logic signed [63:0] x);
    curve_pt_t          r;
    qnum_t              t, r0, r1, b1, sq, ln, kc, acc;
    logic               sat;
    r.value = 0;
    if (kl > kh) begin
      r.status = c1pq_pkg::STAT_ORDER;
    end else if (kl == 0 || kh == 0) begin
      r.status = c1pq_pkg::STAT_SINGULAR;
    end else begin
      t = q_sub(lk, mk);        sat = t.ovf;
      r0 = q_div(t.v, kl);      sat |= r0.ovf;
      t = q_sub(mk, rk);        sat |= t.ovf;
      r1 = q_div(t.v, kh);      sat |= r1.ovf;
      if (x < kl) begin
        t = q_div(r1.v, kh);    sat |= t.ovf;
        sq = q_add(rq, t.v);    sat |= sq.ovf;
        t = q_div(r0.v, kl);    sat |= t.ovf;
        sq = q_add(sq.v, t.v);  sat |= sq.ovf;
        ln.v = ll;
        kc.v = lk;
      end else if (x < kh) begin
        t = q_div(r1.v, kh);    sat |= t.ovf;
        sq = q_add(rq, t.v);    sat |= sq.ovf;
        t = q_add(r0.v, r0.v);  sat |= t.ovf;
        ln = q_add(ll, t.v);    sat |= ln.ovf;
        kc.v = mk;
      end else begin
        t = q_add(r0.v, r0.v);  sat |= t.ovf;
        b1 = q_add(ll, t.v);    sat |= b1.ovf;
        t = q_add(r1.v, r1.v);  sat |= t.ovf;
        ln = q_add(b1.v, t.v);  sat |= ln.ovf;
        sq.v = rq;
        kc.v = rk;
      end
      // Horner: k + x*(l + x*q)
      t = q_mul(x, sq.v);       sat |= t.ovf;
      acc = q_add(ln.v, t.v);   sat |= acc.ovf;
      t = q_mul(x, acc.v);      sat |= t.ovf;
      acc = q_add(kc.v, t.v);   sat |= acc.ovf;
      r.value  = acc.v;
      r.status = sat ? c1pq_pkg::STAT_SAT : c1pq_pkg::STAT_OK;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    curve_pt_t exp_pt;
    if (!rst_n) begin
      kl <= 0; kh <= 0; lk <= 0; ll <= 0; mk <= 0; rk <= 0; rq <= 0;
      curve_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) curve_q.push_back(eval_curve(in_tdata));
      if (out_tvalid && out_tready) begin
        if (curve_q.size() == 0) begin
          $display("%0t: result with nothing expected: value %h status %0d",
                   $time, out_tdata, out_tuser);
          errors <= errors + 1;
        end else begin
          exp_pt = curve_q.pop_front();
          if (exp_pt.value !== out_tdata || exp_pt.status !== out_tuser) begin
            $display("%0t: mismatch: expected value %h status %0d, got value %h status %0d",
                     $time, exp_pt.value, exp_pt.status, out_tdata, out_tuser);
            errors <= errors + 1;
          end
        end
      end
      pending <= curve_q.size();
      if (cfg_we) begin
        case (cfg_index)
          c1pq_pkg::REG_KNOT_LOW:  kl <= cfg_wdata;
          c1pq_pkg::REG_KNOT_HIGH: kh <= cfg_wdata;
          c1pq_pkg::REG_LEFT_K:    lk <= cfg_wdata;
          c1pq_pkg::REG_LEFT_L:    ll <= cfg_wdata;
          c1pq_pkg::REG_MID_K:     mk <= cfg_wdata;
          c1pq_pkg::REG_RIGHT_K:   rk <= cfg_wdata;
          c1pq_pkg::REG_RIGHT_Q:   rq <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: verif/c1_piecewise_quadratic_eval_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c1_piecewise_quadratic_eval_core_test
// Drives sample points through the evaluator core over a series of knot and
// coefficient settings, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module c1_piecewise_quadratic_eval_core_test;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  wire               in_tready;
  logic [63:0]       in_tdata;
  wire               out_tvalid;
  logic              out_tready;
  wire  [63:0]       out_tdata;
  wire  [1:0]        out_tuser;
  logic              cfg_we;
  logic [c1pq_pkg::IDXW-1:0] cfg_index;
  logic [63:0]       cfg_wdata;
  int                errors;
  int                pending;
  int                hold_cycles;
  logic signed [63:0] kl_now, kh_now;

  c1_piecewise_quadratic_eval_core dut (.*);

  c1_piecewise_quadratic_eval_checker checker_i (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  initial begin
    #(12 * 3_000_000);
    $display("c1_piecewise_quadratic_eval_core regression: fail");
    $finish;
  end

  // result side: stall pattern changes every so often; a hold overrides it
  initial begin
    int mode, left;
    out_tready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(30, 200);
      end
      left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 1);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic logic signed [63:0] rand_q(int bits);
    logic signed [63:0] r;
    r = {$urandom, $urandom};
    return r >>> (64 - bits);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_point(logic [63:0] x);
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0 || out_tvalid) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [c1pq_pkg::IDXW-1:0] idx, logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    if (idx == c1pq_pkg::REG_KNOT_LOW)  kl_now = v;
    if (idx == c1pq_pkg::REG_KNOT_HIGH) kh_now = v;
  endtask

  task automatic load_curve(logic signed [63:0] a, logic signed [63:0] b,
                            logic signed [63:0] c, logic signed [63:0] d,
                            logic signed [63:0] e, logic signed [63:0] f,
                            logic signed [63:0] g);
    write_reg(c1pq_pkg::REG_KNOT_LOW, a);
    write_reg(c1pq_pkg::REG_KNOT_HIGH, b);
    write_reg(c1pq_pkg::REG_LEFT_K, c);
    write_reg(c1pq_pkg::REG_LEFT_L, d);
    write_reg(c1pq_pkg::REG_MID_K, e);
    write_reg(c1pq_pkg::REG_RIGHT_K, f);
    write_reg(c1pq_pkg::REG_RIGHT_Q, g);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [63:0] rand_coef();
    if ($urandom_range(0, 9) == 0) return rand_q(64);
    return rand_q($urandom_range(28, 48));
  endfunction

  function automatic logic signed [63:0] rand_point();
    case ($urandom_range(0, 5))
      0:       return kl_now + rand_q($urandom_range(2, 40));
      1:       return kh_now + rand_q($urandom_range(2, 40));
      2:       return rand_q(64);
      default: return rand_q($urandom_range(30, 46));
    endcase
  endfunction

  task automatic run_points(int count);
    int burst;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(negedge clk);
        end
      end
      burst--;
      send_point(rand_point());
    end
  endtask

  initial begin
    logic signed [63:0] a, b, directed[$];
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    hold_cycles = 0;
    kl_now      = 0;
    kh_now      = 0;
    rst_n       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: both knots zero, so every item is singular
    run_points(60);
    drain();

    // directed points on a well-formed curve
    load_curve(-64'sd1 <<< 40, 64'sd3 <<< 40, 64'sd5 <<< 38, -64'sd3 <<< 39,
               64'sd1 <<< 40, -64'sd7 <<< 37, 64'sd1 <<< 39);
    directed = '{0, 1, -1, c1pq_pkg::QMAX, c1pq_pkg::QMIN, 64'sd1 <<< 40,
                 -64'sd1 <<< 40, kl_now, kl_now - 1, kl_now + 1, kh_now,
                 kh_now - 1, kh_now + 1, 64'sd1 <<< 45, -64'sd1 <<< 45,
                 64'sd1 <<< 30};
    foreach (directed[i]) send_point(directed[i]);
    run_points(120);
    drain();

    // knots out of order
    load_curve(64'sd2 <<< 40, -64'sd2 <<< 40, rand_coef(), rand_coef(),
               rand_coef(), rand_coef(), rand_coef());
    run_points(80);
    drain();

    // upper knot zero, lower below it: singular
    load_curve(-64'sd1 <<< 40, 0, rand_coef(), rand_coef(), rand_coef(),
               rand_coef(), rand_coef());
    send_point(0);
    run_points(60);
    drain();

    // equal knots: middle segment never chosen
    a = rand_q(44);
    if (a == 0) a = 1;
    load_curve(a, a, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
               rand_coef());
    send_point(a);
    send_point(a - 1);
    run_points(150);
    drain();

    // extremes of every register
    load_curve(c1pq_pkg::QMIN, c1pq_pkg::QMAX, c1pq_pkg::QMAX, c1pq_pkg::QMIN,
               c1pq_pkg::QMIN, c1pq_pkg::QMAX, c1pq_pkg::QMAX);
    send_point(c1pq_pkg::QMAX);
    send_point(c1pq_pkg::QMIN);
    send_point(0);
    run_points(60);
    drain();
    load_curve(64'sd1, 64'sd1 <<< 40, c1pq_pkg::QMIN, c1pq_pkg::QMAX,
               c1pq_pkg::QMAX, c1pq_pkg::QMIN, c1pq_pkg::QMIN);
    send_point(0);
    send_point(64'sd1 <<< 39);
    run_points(60);
    drain();

    // random well-formed curves; first one stalls the result side long
    for (int p = 0; p < 9; p++) begin
      a = rand_q($urandom_range(20, 46));
      b = rand_q($urandom_range(20, 46));
      if (a == 0) a = 1;
      if (b == 0) b = -1;
      if (a > b) begin
        load_curve(b, a, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                   rand_coef());
      end else begin
        load_curve(a, b, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                   rand_coef());
      end
      if (p == 0) begin
        // long enough to outlast the coefficient recompute and fill the pipe
        hold_cycles = 1200;
        repeat (100) send_point(rand_point());
      end
      run_points(150);
      drain();
    end

    in_tvalid <= 1'b0;
    drain();
    if (errors == 0 && pending == 0) begin
      $display("c1_piecewise_quadratic_eval_core regression: pass");
    end else begin
      $display("c1_piecewise_quadratic_eval_core regression: fail");
    end
    $finish;
  end

endmodule
